[rtl/core/crv_pkg.sv]
// ----------------------------------------------------------------------------
// crv_pkg
// Shared types, constants and arithmetic helpers of the comb/allpass reverb.
// ----------------------------------------------------------------------------
package crv_pkg;

  localparam int NUM_COMBS_DEF     = 8;
  localparam int NUM_ALLPASS_DEF   = 4;
  localparam int COMB_DEPTH_DEF    = 2048;
  localparam int ALLPASS_DEPTH_DEF = 1024;

  localparam int SAMPLE_BITS = 16;
  localparam int DATA_W      = 24;
  localparam int GAIN_W      = 16;

  localparam logic [GAIN_W-1:0] UNITY = 16'd32768;

  localparam logic [GAIN_W-1:0] ROOM_RST     = 16'd16384;
  localparam logic [GAIN_W-1:0] DAMP_RST     = 16'd16384;
  localparam logic [GAIN_W-1:0] WET_RST      = 16'd8192;
  localparam logic [1:0]        CHANNELS_RST = 2'd2;

  typedef enum logic [1:0] {
    REG_ROOM,
    REG_DAMP,
    REG_WET,
    REG_CHANNELS
  } reg_idx_t;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } result_t;

  typedef struct packed {
    logic clr;
    logic rd;
    logic ystep;
    logic mul1;
    logic mul2;
    logic fb;
    logic wr;
  } lane_ctl_t;

  function automatic logic [10:0] comb_base(input logic [2:0] i);
    logic [10:0] r;
    case (i)
      3'd0:    r = 11'd1116;
      3'd1:    r = 11'd1188;
      3'd2:    r = 11'd1277;
      3'd3:    r = 11'd1356;
      3'd4:    r = 11'd1422;
      3'd5:    r = 11'd1491;
      3'd6:    r = 11'd1557;
      default: r = 11'd1617;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] ap_len(input logic [1:0] i);
    logic [9:0] r;
    case (i)
      2'd0:    r = 10'd225;
      2'd1:    r = 10'd556;
      2'd2:    r = 10'd441;
      default: r = 10'd341;
    endcase
    return r;
  endfunction

  function automatic data_t sat24(input logic signed [63:0] v);
    data_t r;
    if (v > 64'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -64'sd8388608) begin
      r = -24'sh800000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat16(input logic signed [63:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/crv_ram.sv]
// ----------------------------------------------------------------------------
// crv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/crv_comb_lane.sv]
// ----------------------------------------------------------------------------
// crv_comb_lane
// One damped comb filter: delay line, damping memory and feedback path.
// ----------------------------------------------------------------------------
module crv_comb_lane #(
  parameter int LANE       = 0,
  parameter int COMB_DEPTH = crv_pkg::COMB_DEPTH_DEF,
  parameter int CLR_W      = 11
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  crv_pkg::lane_ctl_t                    ctl,
  input  logic [CLR_W-1:0]                      clr_addr,
  input  logic signed [crv_pkg::SAMPLE_BITS-1:0] x,
  input  logic [crv_pkg::GAIN_W-1:0]            room,
  input  logic [crv_pkg::GAIN_W-1:0]            damp,
  output crv_pkg::data_t                        y
);

  localparam int PW = $clog2(COMB_DEPTH);
  localparam int LW = $clog2(COMB_DEPTH + 1);
  localparam logic [10:0] BASE = crv_pkg::comb_base(3'(LANE));

  logic [26:0]                 len_prod;
  logic [11:0]                 len_raw;
  logic [LW-1:0]               len;
  logic [PW-1:0]               pos;
  logic [PW-1:0]               pos_use;
  logic [PW-1:0]               pos_eff;
  logic [LW-1:0]               pos_inc;
  logic [PW-1:0]               pos_next;
  logic [crv_pkg::GAIN_W-1:0]  inv_damp;
  logic signed [40:0]          p1;
  logic signed [40:0]          pm;
  logic signed [57:0]          p2;
  crv_pkg::data_t              fb;
  crv_pkg::data_t              m;
  crv_pkg::data_t              d;
  crv_pkg::data_t              line_w;
  logic                        we;
  logic [PW-1:0]               waddr;
  crv_pkg::data_t              wdata;

  assign len_prod = 27'(BASE) * 27'(room);
  assign len_raw  = len_prod[26:15];

  always_comb begin
    if (len_raw == 12'd0) begin
      len = LW'(1);
    end else if (32'(len_raw) > COMB_DEPTH) begin
      len = LW'(COMB_DEPTH);
    end else begin
      len = LW'(len_raw);
    end
  end

  assign pos_eff  = (LW'(pos) >= len) ? '0 : pos;
  assign pos_inc  = LW'(pos_use) + LW'(1);
  assign pos_next = (pos_inc >= len) ? '0 : pos_inc[PW-1:0];
  assign inv_damp = crv_pkg::UNITY - damp;
  assign line_w   = crv_pkg::sat24(64'(x) + 64'(fb));

  always_comb begin
    if (ctl.clr) begin
      we    = ({1'b0, clr_addr} < (CLR_W + 1)'(COMB_DEPTH));
      waddr = PW'(clr_addr);
      wdata = '0;
    end else begin
      we    = ctl.wr;
      waddr = pos_use;
      wdata = line_w;
    end
  end

  crv_ram #(
    .WIDTH(crv_pkg::DATA_W),
    .DEPTH(COMB_DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ctl.rd),
    .raddr(pos_eff),
    .rdata(d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      m   <= '0;
    end else if (ctl.wr) begin
      pos <= pos_next;
      m   <= fb;
    end
    if (ctl.rd) begin
      pos_use <= pos_eff;
    end
    if (ctl.ystep) begin
      y <= crv_pkg::sat24(64'(d) + 64'(x));
    end
    if (ctl.mul1) begin
      p1 <= y * $signed({1'b0, room});
      pm <= m * $signed({1'b0, damp});
    end
    if (ctl.mul2) begin
      p2 <= p1 * $signed({1'b0, inv_damp});
    end
    if (ctl.fb) begin
      fb <= crv_pkg::sat24(64'(p2 >>> 30) + 64'(pm >>> 15));
    end
  end

endmodule

[rtl/core/crv_comb_merge.sv]
// ----------------------------------------------------------------------------
// crv_comb_merge
// Sum the comb outputs and divide by the comb count, truncating toward zero.
// ----------------------------------------------------------------------------
module crv_comb_merge #(
  parameter int NUM_COMBS = crv_pkg::NUM_COMBS_DEF
) (
  input  logic               clk,
  input  crv_pkg::lane_ctl_t ctl,
  input  crv_pkg::data_t     y [NUM_COMBS],
  output crv_pkg::data_t     v
);

  localparam int SW = crv_pkg::DATA_W + $clog2(NUM_COMBS);
  localparam int K  = SW + $clog2(NUM_COMBS);
  localparam logic [K:0] RECIP = (K + 1)'(((64'd1 << K) + 64'(NUM_COMBS) - 64'd1)
                                           / 64'(NUM_COMBS));

  logic signed [SW-1:0] sum_next;
  logic signed [SW-1:0] sum;
  logic [SW-1:0]        mag;
  logic [SW+K:0]        prod;
  logic                 neg;
  logic [SW-1:0]        quo;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < NUM_COMBS; i++) begin
      sum_next = sum_next + SW'(y[i]);
    end
  end

  assign mag = sum[SW-1] ? SW'(-sum) : SW'(sum);
  assign quo = prod[K +: SW];

  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      sum <= sum_next;
    end
    if (ctl.mul2) begin
      prod <= (SW + K + 1)'(mag) * (SW + K + 1)'(RECIP);
      neg  <= sum[SW-1];
    end
    if (ctl.fb) begin
      v <= neg ? crv_pkg::DATA_W'(-quo) : crv_pkg::DATA_W'(quo);
    end
  end

endmodule

[rtl/core/crv_allpass_chain.sv]
// ----------------------------------------------------------------------------
// crv_allpass_chain
// Series allpass stages of gain one half, one stage per cycle while step is high.
// ----------------------------------------------------------------------------
module crv_allpass_chain #(
  parameter int NUM_ALLPASS   = crv_pkg::NUM_ALLPASS_DEF,
  parameter int ALLPASS_DEPTH = crv_pkg::ALLPASS_DEPTH_DEF,
  parameter int CLR_W         = 11,
  parameter int AIW           = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  crv_pkg::lane_ctl_t ctl,
  input  logic [CLR_W-1:0]   clr_addr,
  input  logic               step,
  input  logic [AIW-1:0]     idx,
  input  crv_pkg::data_t     v_in,
  output crv_pkg::data_t     v_out
);

  localparam int PW = $clog2(ALLPASS_DEPTH);
  localparam int LW = $clog2(ALLPASS_DEPTH + 1);

  crv_pkg::data_t d [NUM_ALLPASS];
  crv_pkg::data_t v;
  crv_pkg::data_t d_sel;

  assign d_sel = d[idx];
  assign v_out = v;

  for (genvar k = 0; k < NUM_ALLPASS; k++) begin : g_stage
    localparam int BASE_LEN = int'(crv_pkg::ap_len(2'(k)));
    localparam int LEN      = (BASE_LEN > ALLPASS_DEPTH) ? ALLPASS_DEPTH : BASE_LEN;

    logic [PW-1:0]  pos;
    logic [PW-1:0]  pos_use;
    logic [PW-1:0]  pos_eff;
    logic [LW-1:0]  pos_inc;
    logic           hit;
    logic           we;
    logic [PW-1:0]  waddr;
    crv_pkg::data_t wdata;

    assign pos_eff = (LW'(pos) >= LW'(LEN)) ? '0 : pos;
    assign pos_inc = LW'(pos_use) + LW'(1);
    assign hit     = step && (idx == AIW'(k));

    always_comb begin
      if (ctl.clr) begin
        we    = ({1'b0, clr_addr} < (CLR_W + 1)'(ALLPASS_DEPTH));
        waddr = PW'(clr_addr);
        wdata = '0;
      end else begin
        we    = hit;
        waddr = pos_use;
        wdata = crv_pkg::sat24(64'(v) + 64'(d[k] >>> 1));
      end
    end

    crv_ram #(
      .WIDTH(crv_pkg::DATA_W),
      .DEPTH(ALLPASS_DEPTH)
    ) u_line (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .re   (ctl.rd),
      .raddr(pos_eff),
      .rdata(d[k])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        pos <= '0;
      end else if (hit) begin
        pos <= (pos_inc >= LW'(LEN)) ? '0 : pos_inc[PW-1:0];
      end
      if (ctl.rd) begin
        pos_use <= pos_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      v <= v_in;
    end else if (step) begin
      v <= crv_pkg::sat24(64'(d_sel) - 64'(v));
    end
  end

endmodule

[rtl/core/comb_allpass_reverb.sv]
// ----------------------------------------------------------------------------
// comb_allpass_reverb
// Mono-summing reverb: parallel damped comb lanes, merge, allpass chain, mix.
//
// A frame (left_sample, right_sample) transfers on the sample channel when
// sample_valid is high and sample_stall is low; the mixed frame leaves on the
// result channel under the same rule. One result per frame.
// One frame is processed at a time: sample_stall is high from its transfer
// until its result is in the output register. The comb lanes run their
// read-multiply-write sequence (read, y update, two multiply steps,
// feedback, write), then the allpass stages run one per cycle through the
// shared chain, followed by the mix and output steps.
// The finished frame sits in an output register, so a stalled receiver holds
// the result while the next frame is already taken; a new result waits until
// the register is free.
// After reset all delay memories are zeroed by a sweep of their addresses,
// during which sample_stall is high; configuration writes are taken as ever.
// Registers: room_size 0x0, damping 0x4, wet_mix 0x8, channel_count 0xC.
// ----------------------------------------------------------------------------
module comb_allpass_reverb #(
  parameter int NUM_COMBS     = crv_pkg::NUM_COMBS_DEF,
  parameter int NUM_ALLPASS   = crv_pkg::NUM_ALLPASS_DEF,
  parameter int COMB_DEPTH    = crv_pkg::COMB_DEPTH_DEF,
  parameter int ALLPASS_DEPTH = crv_pkg::ALLPASS_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  crv_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output crv_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CLR_LEN = (COMB_DEPTH > ALLPASS_DEPTH) ? COMB_DEPTH : ALLPASS_DEPTH;
  localparam int CLR_W   = $clog2(CLR_LEN);
  localparam int AIW     = (NUM_ALLPASS > 1) ? $clog2(NUM_ALLPASS) : 1;
  localparam int SB      = crv_pkg::SAMPLE_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_Y, S_MUL1, S_MUL2, S_FB, S_WR, S_AP, S_MIX, S_OUT
  } state_t;

  state_t                      state;
  logic [CLR_W-1:0]            clr_cnt;
  logic [AIW-1:0]              ap_idx;
  logic [crv_pkg::GAIN_W-1:0]  room_size;
  logic [crv_pkg::GAIN_W-1:0]  damping;
  logic [crv_pkg::GAIN_W-1:0]  wet_mix;
  logic [1:0]                  channel_count;
  logic [crv_pkg::GAIN_W-1:0]  room_c;
  logic [crv_pkg::GAIN_W-1:0]  damp_c;
  logic [crv_pkg::GAIN_W-1:0]  wet_c;
  logic [crv_pkg::GAIN_W-1:0]  inv_wet;
  logic signed [SB-1:0]        left;
  logic signed [SB-1:0]        right;
  logic signed [SB-1:0]        x;
  logic signed [SB:0]          lr_sum;
  logic                        stereo;
  logic signed [32:0]          pl;
  logic signed [32:0]          pr;
  logic signed [40:0]          pv;
  logic signed [SB-1:0]        mix_l;
  logic signed [SB-1:0]        mix_r;
  logic                        cfg_write;
  logic                        sample_take;
  logic                        out_free;
  crv_pkg::lane_ctl_t          ctl;
  crv_pkg::data_t              y_lane [NUM_COMBS];
  crv_pkg::data_t              v_comb;
  crv_pkg::data_t              v_rev;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite && pready;
  assign sample_stall = (state != S_IDLE);
  assign sample_take = sample_valid && !sample_stall;
  assign out_free    = !result_valid || !result_stall;

  assign room_c  = (room_size > crv_pkg::UNITY) ? crv_pkg::UNITY : room_size;
  assign damp_c  = (damping > crv_pkg::UNITY) ? crv_pkg::UNITY : damping;
  assign wet_c   = (wet_mix > crv_pkg::UNITY) ? crv_pkg::UNITY : wet_mix;
  assign inv_wet = crv_pkg::UNITY - wet_c;
  assign lr_sum  = (SB + 1)'(sample.left_sample) + (SB + 1)'(sample.right_sample);

  assign ctl.clr   = (state == S_CLEAR);
  assign ctl.rd    = (state == S_RD);
  assign ctl.ystep = (state == S_Y);
  assign ctl.mul1  = (state == S_MUL1);
  assign ctl.mul2  = (state == S_MUL2);
  assign ctl.fb    = (state == S_FB);
  assign ctl.wr    = (state == S_WR);

  always_comb begin
    unique case (paddr[3:2])
      crv_pkg::REG_ROOM:     prdata = 32'(room_size);
      crv_pkg::REG_DAMP:     prdata = 32'(damping);
      crv_pkg::REG_WET:      prdata = 32'(wet_mix);
      crv_pkg::REG_CHANNELS: prdata = 32'(channel_count);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      room_size     <= crv_pkg::ROOM_RST;
      damping       <= crv_pkg::DAMP_RST;
      wet_mix       <= crv_pkg::WET_RST;
      channel_count <= crv_pkg::CHANNELS_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        crv_pkg::REG_ROOM:     room_size     <= pwdata[15:0];
        crv_pkg::REG_DAMP:     damping       <= pwdata[15:0];
        crv_pkg::REG_WET:      wet_mix       <= pwdata[15:0];
        crv_pkg::REG_CHANNELS: channel_count <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  for (genvar c = 0; c < NUM_COMBS; c++) begin : g_lane
    crv_comb_lane #(
      .LANE      (c),
      .COMB_DEPTH(COMB_DEPTH),
      .CLR_W     (CLR_W)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .clr_addr(clr_cnt),
      .x       (x),
      .room    (room_c),
      .damp    (damp_c),
      .y       (y_lane[c])
    );
  end

  crv_comb_merge #(
    .NUM_COMBS(NUM_COMBS)
  ) u_merge (
    .clk(clk),
    .ctl(ctl),
    .y  (y_lane),
    .v  (v_comb)
  );

  crv_allpass_chain #(
    .NUM_ALLPASS  (NUM_ALLPASS),
    .ALLPASS_DEPTH(ALLPASS_DEPTH),
    .CLR_W        (CLR_W),
    .AIW          (AIW)
  ) u_allpass (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .clr_addr(clr_cnt),
    .step    (state == S_AP),
    .idx     (ap_idx),
    .v_in    (v_comb),
    .v_out   (v_rev)
  );

  assign mix_l = crv_pkg::sat16(64'((42'(pl) + 42'(pv)) >>> 15));
  assign mix_r = crv_pkg::sat16(64'((42'(pr) + 42'(pv)) >>> 15));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      ap_idx       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_OUT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CLR_W'(1);
          if (clr_cnt == CLR_W'(CLR_LEN - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (sample_take) begin
            left   <= sample.left_sample;
            right  <= sample.right_sample;
            stereo <= channel_count[1];
            x      <= channel_count[1] ? $signed(lr_sum[SB:1]) : sample.left_sample;
            state  <= S_RD;
          end
        end
        S_RD:   state <= S_Y;
        S_Y:    state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_FB;
        S_FB:   state <= S_WR;
        S_WR: begin
          ap_idx <= '0;
          state  <= S_AP;
        end
        S_AP: begin
          ap_idx <= ap_idx + AIW'(1);
          if (ap_idx == AIW'(NUM_ALLPASS - 1)) begin
            state <= S_MIX;
          end
        end
        S_MIX: begin
          pl    <= left * $signed({1'b0, inv_wet});
          pr    <= right * $signed({1'b0, inv_wet});
          pv    <= v_rev * $signed({1'b0, wet_c});
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            result.left_out  <= mix_l;
            result.right_out <= stereo ? mix_r : '0;
            result_valid     <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    sample_take |=> (state == S_RD))
    else $error("frame transfer did not start the comb sequence");

  a_ap_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_AP) |-> (32'(ap_idx) < NUM_ALLPASS))
    else $error("allpass stage index out of range");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_OUT))
    else $error("result raised outside the output step");

  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !result_valid || $past(result_valid))
    else $error("result appeared during the clearing sweep");

endmodule
